// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/ctw_pkg.sv =====
// types, constants and helper functions of the countdown timer
`timescale 1ns / 1ps

package ctw_pkg;

	localparam int DurW   = 16;
	localparam int RemW   = 31;
	localparam int RingW  = 16;
	localparam int NudgeW = 20;
	localparam int ReqW   = 3;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 20;

	localparam logic [DurW-1:0]  MinSecReset   = 16'd15;
	localparam logic [DurW-1:0]  MaxSecReset   = 16'd5940;
	localparam logic [RingW-1:0] RingMsReset   = 16'd30000;
	localparam logic [NudgeW-1:0] NudgeMsReset = 20'd60000;
	localparam logic [DurW-1:0]  DurReset      = 16'd300;
	localparam logic [RemW-1:0]  RemReset      = 31'd300000;
	localparam logic [RemW-1:0]  RemMax        = 31'h7fff_ffff;
	localparam logic [RingW-1:0] RingMax       = 16'hffff;
	localparam logic [RemW-1:0]  MsPerSec      = 31'd1000;
	localparam logic [DurW-1:0]  MinuteSec     = 16'd60;
	localparam logic signed [17:0] StepSmall   = 18'sd15;
	localparam logic signed [17:0] StepLarge   = 18'sd60;

	typedef enum logic [ReqW-1:0] {
		REQ_TICK   = 3'd0,
		REQ_ADJUST = 3'd1,
		REQ_TOGGLE = 3'd2,
		REQ_RESET  = 3'd3,
		REQ_SET    = 3'd4
	} req_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_MIN_SEC = 2'd0,
		CFG_MAX_SEC = 2'd1,
		CFG_RING_MS = 2'd2,
		CFG_NUDGE   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [DurW-1:0]   dur;
		logic [RemW-1:0]   rem;
		logic              run;
		logic              expired;
		logic [RingW-1:0]  ring;
	} tmr_state_t;

	typedef struct packed {
		logic [DurW-1:0]   min_sec;
		logic [DurW-1:0]   max_sec;
		logic [RingW-1:0]  ring_ms;
		logic [NudgeW-1:0] nudge_ms;
	} tmr_cfg_t;

	typedef struct packed {
		logic [ReqW-1:0]  req;
		logic             up;
		logic [DurW-1:0]  dsec;
	} tmr_req_t;

	// seconds to milliseconds, a constant multiply
	function automatic logic [RemW-1:0] sec_to_ms(input logic [DurW-1:0] s);
		return RemW'(s) * MsPerSec;
	endfunction

	// clamp: below the minimum wins first, then above the maximum
	function automatic logic [DurW-1:0] clamp_dur(input logic signed [17:0] x,
			input logic [DurW-1:0] lo, input logic [DurW-1:0] hi);
		logic signed [17:0] lo_s;
		logic signed [17:0] hi_s;
		lo_s = $signed({2'b00, lo});
		hi_s = $signed({2'b00, hi});
		if (x < lo_s) begin
			return lo;
		end else if (x > hi_s) begin
			return hi;
		end
		return x[DurW-1:0];
	endfunction

endpackage

// ===== rtl/countdown_timer_with_ring_core.sv =====
// Countdown timer driven by millisecond tick words, with an auto-dismissing ring.
// Each request word on the slave stream gives exactly one status word on the master
// stream. A word is held in the input register, where the next-state logic updates
// the timer state and loads the output register, which presents the result on the
// master stream. A new word is taken every cycle while the master side does not
// stall; the state feedback through the next-state logic sets that rate.
// Back-pressure on the master side holds the input register and then drops s_tready.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must keep
// the stream idle (unchecked); index 0 min sec, 1 max sec, 2 ring ms, 3 nudge ms.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module countdown_timer_with_ring_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // direction, duration_sec, zero fill
	input  logic [2:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // remaining_ms, set_sec, is_running, is_expired,
	                               // expired_event, zero fill
);

	ctw_pkg::tmr_cfg_t   cfg_q;
	ctw_pkg::tmr_state_t st_q;
	ctw_pkg::tmr_state_t st_nxt;
	ctw_pkg::tmr_req_t   rq_s1;
	logic                vld_s1;
	logic                adv;
	logic                event_hit;
	logic                out_vld_q;
	logic [49:0]         out_q;

	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'd0, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_sec  <= ctw_pkg::MinSecReset;
			cfg_q.max_sec  <= ctw_pkg::MaxSecReset;
			cfg_q.ring_ms  <= ctw_pkg::RingMsReset;
			cfg_q.nudge_ms <= ctw_pkg::NudgeMsReset;
		end else if (cfg_we) begin
			case (cfg_index)
				ctw_pkg::CFG_MIN_SEC: cfg_q.min_sec  <= cfg_data[15:0];
				ctw_pkg::CFG_MAX_SEC: cfg_q.max_sec  <= cfg_data[15:0];
				ctw_pkg::CFG_RING_MS: cfg_q.ring_ms  <= cfg_data[15:0];
				ctw_pkg::CFG_NUDGE:   cfg_q.nudge_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rq_s1.req  <= s_tuser;
			rq_s1.up   <= s_tdata[0];
			rq_s1.dsec <= s_tdata[16:1];
		end
	end

	ctw_next u_next (
		.cur       (st_q),
		.cfg       (cfg_q),
		.rq        (rq_s1),
		.nxt       (st_nxt),
		.event_hit (event_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.dur     <= ctw_pkg::DurReset;
			st_q.rem     <= ctw_pkg::RemReset;
			st_q.run     <= 1'b0;
			st_q.expired <= 1'b0;
			st_q.ring    <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= {event_hit, st_nxt.expired, st_nxt.run, st_nxt.dur, st_nxt.rem};
		end
	end

	`ASSERT_NOW(a_run_exp_excl, 1'b1, !(st_q.run && st_q.expired), "running and expired together")
	`ASSERT_NOW(a_ring_idle, !st_q.expired, st_q.ring == '0, "ring count live while not expired")
	`ASSERT_NOW(a_event_word, m_tvalid && out_q[49], out_q[48] && !out_q[47],
		"expiry word without expired status")
	`ASSERT_NEXT(a_state_hold, !adv, $stable(st_q), "timer state moved without a word")
	`ASSERT_NOW(a_ready_free, !out_vld_q, s_tready, "input stalled with output empty")

endmodule

// ===== rtl/ctw_next.sv =====
// next-state logic of the countdown timer for one request word
`timescale 1ns / 1ps

module ctw_next (
	input  ctw_pkg::tmr_state_t cur,
	input  ctw_pkg::tmr_cfg_t   cfg,
	input  ctw_pkg::tmr_req_t   rq,
	output ctw_pkg::tmr_state_t nxt,
	output logic                event_hit
);

	logic [ctw_pkg::RemW-1:0]  dur_ms;
	logic [ctw_pkg::RemW-1:0]  rem_dec;
	logic [ctw_pkg::RingW-1:0] ring_inc;
	logic [ctw_pkg::RemW:0]    rem_sum;
	logic [ctw_pkg::RemW-1:0]  rem_up;
	logic [ctw_pkg::RemW-1:0]  rem_down;
	logic [ctw_pkg::RemW-1:0]  nudge_ext;
	logic signed [17:0]        step;
	logic signed [17:0]        adj_x;
	logic [ctw_pkg::DurW-1:0]  adj_dur;
	logic [ctw_pkg::DurW-1:0]  set_dur;
	logic                      untouched;

	always_comb begin
		dur_ms    = ctw_pkg::sec_to_ms(cur.dur);
		rem_dec   = (cur.rem != '0) ? cur.rem - 1'b1 : cur.rem;
		ring_inc  = (cur.ring != ctw_pkg::RingMax) ? cur.ring + 1'b1 : cur.ring;
		nudge_ext = ctw_pkg::RemW'(cfg.nudge_ms);
		rem_sum   = {1'b0, cur.rem} + {1'b0, nudge_ext};
		rem_up    = rem_sum[ctw_pkg::RemW] ? ctw_pkg::RemMax : rem_sum[ctw_pkg::RemW-1:0];
		rem_down  = (cur.rem < nudge_ext) ? '0 : cur.rem - nudge_ext;
		untouched = !cur.run && (cur.rem == dur_ms);

		// 60 s steps above one minute, 15 s below
		if (rq.up) begin
			step  = (cur.dur < ctw_pkg::MinuteSec) ? ctw_pkg::StepSmall : ctw_pkg::StepLarge;
			adj_x = $signed({2'b00, cur.dur}) + step;
		end else begin
			step  = (cur.dur <= ctw_pkg::MinuteSec) ? ctw_pkg::StepSmall : ctw_pkg::StepLarge;
			adj_x = $signed({2'b00, cur.dur}) - step;
		end
		adj_dur = ctw_pkg::clamp_dur(adj_x, cfg.min_sec, cfg.max_sec);
		set_dur = ctw_pkg::clamp_dur($signed({2'b00, rq.dsec}), cfg.min_sec, cfg.max_sec);

		nxt       = cur;
		event_hit = 1'b0;

		case (rq.req)
			ctw_pkg::REQ_TICK: begin
				if (cur.run) begin
					nxt.rem = rem_dec;
					if (rem_dec == '0) begin
						nxt.run     = 1'b0;
						nxt.expired = 1'b1;
						nxt.ring    = '0;
						event_hit   = 1'b1;
					end
				end else if (cur.expired) begin
					if (ring_inc >= cfg.ring_ms) begin
						nxt.expired = 1'b0;
						nxt.ring    = '0;
						nxt.rem     = dur_ms;
					end else begin
						nxt.ring = ring_inc;
					end
				end
			end
			ctw_pkg::REQ_ADJUST: begin
				if (!cur.expired) begin
					if (untouched) begin
						nxt.dur = adj_dur;
						nxt.rem = ctw_pkg::sec_to_ms(adj_dur);
					end else begin
						nxt.rem = rq.up ? rem_up : rem_down;
					end
				end
			end
			ctw_pkg::REQ_TOGGLE: begin
				if (cur.expired) begin
					nxt.run     = 1'b0;
					nxt.expired = 1'b0;
					nxt.ring    = '0;
					nxt.rem     = dur_ms;
				end else if (cur.run) begin
					nxt.run = 1'b0;
				end else if (cur.rem != '0) begin
					nxt.run = 1'b1;
				end
			end
			ctw_pkg::REQ_RESET: begin
				nxt.run     = 1'b0;
				nxt.expired = 1'b0;
				nxt.ring    = '0;
				nxt.rem     = dur_ms;
			end
			ctw_pkg::REQ_SET: begin
				nxt.dur = set_dur;
				if (!cur.run && !cur.expired) begin
					nxt.rem = ctw_pkg::sec_to_ms(set_dur);
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== verif/countdown_timer_with_ring_checker.sv =====
// status word checker for the countdown timer: tracks timer state and compares every word
`timescale 1ns / 1ps

module countdown_timer_with_ring_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ctw_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [ctw_pkg::CfgDataW-1:0] cfg_data,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [23:0]                  s_tdata,   // direction, duration_sec, zero fill
	input  logic [2:0]                   s_tuser,   // req_type
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [55:0]                  m_tdata,   // remaining_ms, set_sec, is_running,
	                                                // is_expired, expired_event, zero fill
	output int                           errors,
	output int                           pending
);
	import ctw_pkg::*;

	localparam longint MsPerS     = 1000;
	localparam longint StepFine   = 15;
	localparam longint StepCoarse = 60;
	localparam longint MinuteS    = 60;
	localparam longint RemCeiling = 64'h7fff_ffff;

	typedef struct packed {
		logic [RemW-1:0] rem;
		logic [DurW-1:0] sec;
		logic            run;
		logic            expired;
		logic            fired;
	} status_t;

	status_t status_q[$];
	status_t want;

	// timer state as the block should hold it
	logic [DurW-1:0]   t_dur;
	logic [RemW-1:0]   t_rem;
	logic              t_run;
	logic              t_exp;
	logic [RingW-1:0]  t_ring;

	// register copies
	logic [DurW-1:0]   c_min;
	logic [DurW-1:0]   c_max;
	logic [RingW-1:0]  c_ring;
	logic [NudgeW-1:0] c_nudge;

	function automatic longint dur_ms(input logic [DurW-1:0] s);
		return longint'(s) * MsPerS;
	endfunction

	// below the minimum wins before above the maximum
	function automatic logic [DurW-1:0] fit_duration(input longint x);
		if (x < longint'(c_min)) return c_min;
		if (x > longint'(c_max)) return c_max;
		return x[DurW-1:0];
	endfunction

	function automatic void dismiss_timer();
		t_run  = 1'b0;
		t_exp  = 1'b0;
		t_ring = '0;
		t_rem  = RemW'(dur_ms(t_dur));
	endfunction

	function automatic status_t advance_timer(input logic [ReqW-1:0] req, input logic up,
			input logic [DurW-1:0] dsec);
		status_t st;
		longint  r;
		longint  s;
		longint  step;
		logic    fired;
		fired = 1'b0;
		case (req)
			REQ_TICK: begin
				if (t_run) begin
					if (t_rem != 0) t_rem = t_rem - 1'b1;
					if (t_rem == 0) begin
						t_run  = 1'b0;
						t_exp  = 1'b1;
						t_ring = '0;
						fired  = 1'b1;
					end
				end else if (t_exp) begin
					if (t_ring != RingMax) t_ring = t_ring + 1'b1;
					if (t_ring >= c_ring) dismiss_timer();
				end
			end
			REQ_ADJUST: begin
				if (!t_exp) begin
					if (!t_run && longint'(t_rem) == dur_ms(t_dur)) begin
						// untouched timer: step the set duration itself
						s = longint'(t_dur);
						if (up) step = (s < MinuteS) ? StepFine : StepCoarse;
						else step = (s <= MinuteS) ? StepFine : StepCoarse;
						t_dur = fit_duration(up ? s + step : s - step);
						t_rem = RemW'(dur_ms(t_dur));
					end else begin
						r = longint'(t_rem);
						r = up ? r + longint'(c_nudge) : r - longint'(c_nudge);
						if (r < 0) r = 0;
						if (r > RemCeiling) r = RemCeiling;
						t_rem = r[RemW-1:0];
					end
				end
			end
			REQ_TOGGLE: begin
				if (t_exp) dismiss_timer();
				else if (t_run) t_run = 1'b0;
				else if (t_rem != 0) t_run = 1'b1;
			end
			REQ_RESET: dismiss_timer();
			REQ_SET: begin
				t_dur = fit_duration(longint'(dsec));
				if (!t_run && !t_exp) t_rem = RemW'(dur_ms(t_dur));
			end
			default: ;
		endcase
		st.rem     = t_rem;
		st.sec     = t_dur;
		st.run     = t_run;
		st.expired = t_exp;
		st.fired   = fired;
		return st;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_dur   = DurReset;
			t_rem   = RemReset;
			t_run   = 1'b0;
			t_exp   = 1'b0;
			t_ring  = '0;
			c_min   = MinSecReset;
			c_max   = MaxSecReset;
			c_ring  = RingMsReset;
			c_nudge = NudgeMsReset;
			status_q.delete();
			pending = 0;
		end else begin
			// the word leaving now belongs to an older request, so retire it first
			if (m_tvalid && m_tready) begin
				if (status_q.size() == 0) begin
					$display("%0t: status word %h arrived with none expected", $time, m_tdata);
					errors++;
				end else begin
					want = status_q.pop_front();
					check_field("remaining_ms", 32'(want.rem), 32'(m_tdata[30:0]));
					check_field("set_sec", 32'(want.sec), 32'(m_tdata[46:31]));
					check_field("is_running", 32'(want.run), 32'(m_tdata[47]));
					check_field("is_expired", 32'(want.expired), 32'(m_tdata[48]));
					check_field("expired_event", 32'(want.fired), 32'(m_tdata[49]));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_SEC: c_min = cfg_data[DurW-1:0];
					CFG_MAX_SEC: c_max = cfg_data[DurW-1:0];
					CFG_RING_MS: c_ring = cfg_data[RingW-1:0];
					CFG_NUDGE:   c_nudge = cfg_data[NudgeW-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				status_q.push_back(advance_timer(s_tuser, s_tdata[0], s_tdata[16:1]));
			end
			pending = status_q.size();
		end
	end

endmodule

// ===== verif/tb_countdown_timer_with_ring_core.sv =====
// regression top for the countdown timer: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb_countdown_timer_with_ring_core;
	import ctw_pkg::*;

	localparam logic [ReqW-1:0] ReqSpareA = 3'd5;
	localparam logic [ReqW-1:0] ReqSpareB = 3'd6;
	localparam logic [ReqW-1:0] ReqSpareC = 3'd7;
	localparam int CycleLimit  = 2000000;
	localparam int ClimbWords  = 300;
	localparam int PhaseWords  = 110;
	localparam int PhaseCount  = 8;
	localparam int LongHold    = 300;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [23:0]         s_tdata;
	logic [2:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [55:0]         m_tdata;

	int check_errors;
	int check_pending;
	int cycles;
	int words_sent;
	bit sender_burst;
	bit hold_ask;

	countdown_timer_with_ring_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	countdown_timer_with_ring_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.errors    (check_errors),
		.pending   (check_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_word(input logic [ReqW-1:0] req, input logic up,
			input logic [DurW-1:0] dsec);
		int gap;
		gap = sender_burst ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, dsec, up};
		s_tuser  <= req;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (check_pending != 0) @(negedge clk);
	endtask

	task automatic load_config(input logic [DurW-1:0] min_s, input logic [DurW-1:0] max_s,
			input logic [RingW-1:0] ring, input logic [NudgeW-1:0] nudge);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MIN_SEC;
		cfg_data  <= CfgDataW'(min_s);
		@(negedge clk);
		cfg_index <= CFG_MAX_SEC;
		cfg_data  <= CfgDataW'(max_s);
		@(negedge clk);
		cfg_index <= CFG_RING_MS;
		cfg_data  <= CfgDataW'(ring);
		@(negedge clk);
		cfg_index <= CFG_NUDGE;
		cfg_data  <= nudge;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// set a short duration, start, pull the time down and tick through expiry and ring
	task automatic countdown_run();
		int n;
		int i;
		send_word(REQ_SET, 1'($urandom_range(0, 1)),
			($urandom_range(0, 3) == 0) ? DurW'($urandom_range(0, 65535))
				: DurW'($urandom_range(0, 4)));
		n = $urandom_range(0, 2);
		for (i = 0; i < n; i++) begin
			send_word(REQ_ADJUST, 1'($urandom_range(0, 1)), DurW'($urandom_range(0, 65535)));
		end
		send_word(REQ_TOGGLE, 1'($urandom_range(0, 1)), DurW'($urandom_range(0, 65535)));
		n = $urandom_range(0, 3);
		for (i = 0; i < n; i++) begin
			send_word(REQ_ADJUST, ($urandom_range(0, 3) == 0), DurW'($urandom_range(0, 65535)));
		end
		n = $urandom_range(0, 40);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				send_word(REQ_TOGGLE, 1'b0, DurW'($urandom_range(0, 65535)));
			end else begin
				send_word(REQ_TICK, 1'($urandom_range(0, 1)), DurW'($urandom_range(0, 65535)));
			end
		end
		n = $urandom_range(0, 25);
		for (i = 0; i < n; i++) begin
			send_word(REQ_TICK, 1'($urandom_range(0, 1)), DurW'($urandom_range(0, 65535)));
		end
		case ($urandom_range(0, 2))
			0: send_word(REQ_TOGGLE, 1'($urandom_range(0, 1)), DurW'($urandom_range(0, 65535)));
			1: send_word(REQ_RESET, 1'($urandom_range(0, 1)), DurW'($urandom_range(0, 65535)));
			default: ;
		endcase
	endtask

	task automatic random_phase(input int count);
		int stop_at;
		int n;
		int i;
		stop_at = words_sent + count;
		while (words_sent < stop_at) begin
			sender_burst = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				7: begin
					// broken sequence of valid request codes
					n = $urandom_range(1, 8);
					for (i = 0; i < n; i++) begin
						send_word(ReqW'($urandom_range(0, 4)), 1'($urandom_range(0, 1)),
							DurW'($urandom_range(0, 65535)));
					end
				end
				8, 9: begin
					n = $urandom_range(1, 6);
					for (i = 0; i < n; i++) begin
						send_word(ReqW'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
							DurW'($urandom_range(0, 65535)));
					end
				end
				default: countdown_run();
			endcase
		end
	endtask

	// result side: random stalls, calm stretches, and one long hold-off on request
	initial begin
		int stall_left;
		int mode_left;
		bit calm;
		stall_left = 0;
		mode_left  = 0;
		calm       = 1'b0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_ask) begin
				hold_ask   = 1'b0;
				stall_left = LongHold;
			end
			if (mode_left == 0) begin
				calm      = ($urandom_range(0, 2) == 0);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!calm) stall_left = pick_gap();
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("countdown_timer_with_ring_core regression: fail");
		$finish;
	end

	initial begin
		int p;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_MIN_SEC;
		cfg_data     = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = REQ_TICK;
		sender_burst = 1'b0;
		hold_ask     = 1'b0;
		words_sent   = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words on the reset registers, duration starting at 300 s
		send_word(REQ_TICK, 1'b0, 16'd0);          // idle tick leaves everything alone
		send_word(REQ_ADJUST, 1'b1, 16'hffff);     // untouched, a minute up
		send_word(REQ_SET, 1'b1, 16'd0);           // clamped up to the minimum
		send_word(REQ_ADJUST, 1'b0, 16'd0);        // down from the minimum stays there
		send_word(REQ_ADJUST, 1'b1, 16'd0);        // 15 s steps below a minute
		send_word(REQ_SET, 1'b0, 16'hffff);        // clamped down to the maximum
		send_word(REQ_ADJUST, 1'b1, 16'd0);        // up at the maximum
		send_word(REQ_SET, 1'b0, 16'd60);
		send_word(REQ_ADJUST, 1'b1, 16'd0);        // up from exactly a minute goes by 60
		send_word(REQ_ADJUST, 1'b0, 16'd0);        // down from above a minute goes by 60
		send_word(REQ_ADJUST, 1'b0, 16'd0);        // down from a minute goes by 15
		send_word(REQ_TOGGLE, 1'b0, 16'd0);        // start
		send_word(REQ_TICK, 1'b1, 16'hffff);
		send_word(REQ_ADJUST, 1'b1, 16'd0);        // nudge up while running
		send_word(REQ_ADJUST, 1'b0, 16'd0);
		send_word(REQ_ADJUST, 1'b0, 16'd0);        // floors at zero, still running
		send_word(REQ_TICK, 1'b0, 16'd0);          // running at zero expires
		send_word(REQ_TICK, 1'b0, 16'd0);          // ring counts
		send_word(REQ_ADJUST, 1'b1, 16'd0);        // ignored while expired
		send_word(REQ_SET, 1'b0, 16'd90);          // duration only, no reload
		send_word(REQ_TOGGLE, 1'b0, 16'd0);        // dismiss
		send_word(REQ_TOGGLE, 1'b0, 16'd0);
		send_word(REQ_TICK, 1'b0, 16'd0);
		send_word(REQ_TOGGLE, 1'b0, 16'd0);        // pause
		send_word(REQ_ADJUST, 1'b0, 16'd0);
		send_word(REQ_ADJUST, 1'b0, 16'd0);        // paused at zero
		send_word(REQ_TOGGLE, 1'b0, 16'd0);        // no start with nothing left
		send_word(REQ_RESET, 1'b1, 16'hffff);
		send_word(ReqSpareA, 1'b1, 16'hffff);
		send_word(ReqSpareB, 1'b0, 16'h5a5a);
		send_word(ReqSpareC, 1'b1, 16'ha5a5);
		drain();

		// climb the remaining time with the largest nudge
		load_config(16'd1, 16'd65535, 16'd5, 20'd600000);
		sender_burst = 1'b1;
		send_word(REQ_RESET, 1'b0, 16'd0);
		send_word(REQ_TOGGLE, 1'b0, 16'd0);
		repeat (ClimbWords) send_word(REQ_ADJUST, 1'b1, DurW'($urandom_range(0, 65535)));
		send_word(REQ_TICK, 1'b0, 16'd0);
		send_word(REQ_ADJUST, 1'b0, 16'd0);
		send_word(REQ_TOGGLE, 1'b0, 16'd0);
		send_word(REQ_RESET, 1'b0, 16'd0);
		sender_burst = 1'b0;
		drain();

		for (p = 0; p < PhaseCount; p++) begin
			case (p)
				0: load_config(16'd1, 16'd5940, 16'd5, 20'd600000);
				1: load_config(16'd1, 16'd3, 16'd0, 20'd999);
				2: load_config(16'd65535, 16'd1, 16'd65535, 20'd0);
				3: load_config(16'd60, 16'd65535, 16'd3, 20'd1000);
				4: load_config(16'd1, 16'd1, 16'd1, 20'd1);
				default: load_config(DurW'($urandom_range(1, 120)), DurW'($urandom_range(1, 400)),
					RingW'($urandom_range(0, 40)), NudgeW'($urandom_range(0, 600000)));
			endcase
			// hold the result side off once while requests keep coming
			if (p == 0) hold_ask = 1'b1;
			random_phase(PhaseWords);
			drain();
		end

		repeat (8) @(negedge clk);
		if (check_errors == 0) begin
			$display("countdown_timer_with_ring_core regression: pass");
		end else begin
			$display("countdown_timer_with_ring_core regression: fail");
		end
		$finish;
	end

endmodule
